FILE: hw/rtl/gcvq_pkg.sv
// ============================================================================
// gcvq_pkg: shared definitions for the genotype count variant filter
// Field widths, fixed-point formats, genotype codes and register indexes.
// ============================================================================
package gcvq_pkg;

  // Largest number of samples counted per variant; the sample tally saturates.
  localparam int MAX_SAMPLES = 65535;
  localparam int SAMPLE_W    = $clog2(MAX_SAMPLES + 1);

  // Input field widths.
  localparam int DEPTH_W = 16;
  localparam int QUAL_W  = 8;
  localparam int GT_W    = 2;

  // Call tallies and the quantities derived from them.
  localparam int TALLY_W  = 16;
  localparam int PAIR_W   = TALLY_W + 1;
  localparam int ALLELE_W = TALLY_W + 2;
  localparam int CALLS_W  = TALLY_W + 2;
  localparam int TOTAL_W  = TALLY_W + 3;
  localparam int MINOR_W  = 17;

  // Unsigned Q0.16 fractions, held in 17 bits so that 1.0 is representable.
  localparam int FRAC_W = 16;
  localparam int Q_W    = FRAC_W + 1;

  // Products used by the frequency and call-rate tests.
  localparam int FREQ_PROD_W = Q_W + TOTAL_W;
  localparam int RATE_PROD_W = Q_W + SAMPLE_W;
  localparam int CMP_W = (RATE_PROD_W > FREQ_PROD_W) ? RATE_PROD_W : FREQ_PROD_W;

  localparam logic [TALLY_W-1:0]  TALLY_MAX   = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = SAMPLE_W'(MAX_SAMPLES);
  localparam logic [MINOR_W-1:0]  MINOR_MAX   = '1;

  // Genotype codes.
  localparam logic [GT_W-1:0] GT_HOM_REF = 2'd0;
  localparam logic [GT_W-1:0] GT_HET     = 2'd1;
  localparam logic [GT_W-1:0] GT_HOM_ALT = 2'd2;

  // Configuration bus.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_DEPTH       = 3'd0,
    REG_MIN_QUALITY     = 3'd1,
    REG_MIN_FREQ        = 3'd2,
    REG_MAX_FREQ        = 3'd3,
    REG_MIN_CALL_RATE   = 3'd4,
    REG_MIN_MINOR_COUNT = 3'd5,
    REG_MAX_MINOR_COUNT = 3'd6,
    REG_KEEP_SINGLETONS = 3'd7
  } cfg_reg_t;

endpackage

FILE: hw/rtl/gcvq_ifs.sv
// ============================================================================
// gcvq_ifs: stream interfaces of the genotype count variant filter
// One interface for sample calls coming in and one for variant results.
// ============================================================================
interface gcvq_in_if import gcvq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DEPTH_W-1:0]  depth;
  logic [QUAL_W-1:0]   quality;
  logic [GT_W-1:0]     genotype;
  logic                last_sample;

  modport source (output valid, depth, quality, genotype, last_sample, input ready);
  modport sink   (input valid, depth, quality, genotype, last_sample, output ready);
endinterface

interface gcvq_out_if import gcvq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TALLY_W-1:0]  hom_ref_count;
  logic [TALLY_W-1:0]  het_count;
  logic [TALLY_W-1:0]  hom_alt_count;
  logic [MINOR_W-1:0]  minor_count;
  logic                passes;

  modport source (output valid, hom_ref_count, het_count, hom_alt_count, minor_count, passes,
                  input ready);
  modport sink   (input valid, hom_ref_count, het_count, hom_alt_count, minor_count, passes,
                  output ready);
endinterface

FILE: hw/rtl/genotype_count_variant_qc.sv
// ============================================================================
// genotype_count_variant_qc: per-variant genotype tally and quality filter
// Counts qualified genotype calls per variant and emits counts and a pass flag.
// ============================================================================
// The block takes one sample call per clock cycle on in_chan and produces one
// result on out_chan for every call that carries last_sample. A final call
// passes the input register, where the running tallies are updated, then the
// allele sums, the three multiplications and the filter comparisons into the
// output register. The running tally update is the only feedback loop, so the
// block sustains one call per cycle as long as results are taken; a stalled
// result holds back the input only once every later stage is full and a
// final call waits in the input register; until then, non-final calls keep
// flowing into the tallies. The user must write registers over the APB port
// only while no variant is in flight; the block does not enforce this. Each
// register sits at byte address 4 times its index and reads back its value.
module genotype_count_variant_qc import gcvq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gcvq_in_if.sink               in_chan,
  gcvq_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Stage payload types.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [QUAL_W-1:0]  quality;
    logic [GT_W-1:0]    genotype;
    logic               last_sample;
  } call_t;

  typedef struct packed {
    logic [TALLY_W-1:0]  ref_cnt;
    logic [TALLY_W-1:0]  het_cnt;
    logic [TALLY_W-1:0]  alt_cnt;
    logic [SAMPLE_W-1:0] smp_cnt;
  } tally_t;

  typedef struct packed {
    logic [TALLY_W-1:0]  ref_cnt;
    logic [TALLY_W-1:0]  het_cnt;
    logic [TALLY_W-1:0]  alt_cnt;
    logic [SAMPLE_W-1:0] smp_cnt;
    logic [ALLELE_W-1:0] minor;
    logic [TOTAL_W-1:0]  total;
    logic [CALLS_W-1:0]  calls;
    logic                cnt_ok;
    logic                allele_ok;
    logic                single_ok;
  } sums_t;

  typedef struct packed {
    logic [TALLY_W-1:0]     ref_cnt;
    logic [TALLY_W-1:0]     het_cnt;
    logic [TALLY_W-1:0]     alt_cnt;
    logic [ALLELE_W-1:0]    minor;
    logic [CALLS_W-1:0]     calls;
    logic [RATE_PROD_W-1:0] rate_rhs;
    logic [FREQ_PROD_W-1:0] freq_lo;
    logic [FREQ_PROD_W-1:0] freq_hi;
    logic                   cnt_ok;
    logic                   allele_ok;
    logic                   single_ok;
  } prod_t;

  typedef struct packed {
    logic [TALLY_W-1:0] hom_ref_count;
    logic [TALLY_W-1:0] het_count;
    logic [TALLY_W-1:0] hom_alt_count;
    logic [MINOR_W-1:0] minor_count;
    logic               passes;
  } result_t;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [DEPTH_W-1:0] min_depth_r;
  logic [QUAL_W-1:0]  min_quality_r;
  logic [Q_W-1:0]     min_freq_r;
  logic [Q_W-1:0]     max_freq_r;
  logic [Q_W-1:0]     min_call_rate_r;
  logic [MINOR_W-1:0] min_minor_count_r;
  logic [MINOR_W-1:0] max_minor_count_r;
  logic               keep_singletons_r;

  cfg_reg_t cfg_idx;
  logic     cfg_wr;

  // The low address bits are not decoded, so any byte address within a word
  // reaches that word's register.
  assign cfg_idx = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_depth_r       <= '0;
      min_quality_r     <= '0;
      min_freq_r        <= '0;
      max_freq_r        <= Q_W'(1) << FRAC_W;
      min_call_rate_r   <= '0;
      min_minor_count_r <= '0;
      max_minor_count_r <= MINOR_MAX - MINOR_W'(1);
      keep_singletons_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_DEPTH:       min_depth_r       <= pwdata[DEPTH_W-1:0];
        REG_MIN_QUALITY:     min_quality_r     <= pwdata[QUAL_W-1:0];
        REG_MIN_FREQ:        min_freq_r        <= pwdata[Q_W-1:0];
        REG_MAX_FREQ:        max_freq_r        <= pwdata[Q_W-1:0];
        REG_MIN_CALL_RATE:   min_call_rate_r   <= pwdata[Q_W-1:0];
        REG_MIN_MINOR_COUNT: min_minor_count_r <= pwdata[MINOR_W-1:0];
        REG_MAX_MINOR_COUNT: max_minor_count_r <= pwdata[MINOR_W-1:0];
        REG_KEEP_SINGLETONS: keep_singletons_r <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_DEPTH:       prdata = APB_DATA_W'(min_depth_r);
      REG_MIN_QUALITY:     prdata = APB_DATA_W'(min_quality_r);
      REG_MIN_FREQ:        prdata = APB_DATA_W'(min_freq_r);
      REG_MAX_FREQ:        prdata = APB_DATA_W'(max_freq_r);
      REG_MIN_CALL_RATE:   prdata = APB_DATA_W'(min_call_rate_r);
      REG_MIN_MINOR_COUNT: prdata = APB_DATA_W'(min_minor_count_r);
      REG_MAX_MINOR_COUNT: prdata = APB_DATA_W'(max_minor_count_r);
      REG_KEEP_SINGLETONS: prdata = APB_DATA_W'(keep_singletons_r);
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage takes new data when it is empty or when
  // its contents move on. Only calls that end a variant enter the stages after
  // the input register; the others are absorbed into the tallies.
  // --------------------------------------------------------------------------
  logic    s0_vld_r, s0_vld_nxt;
  logic    s1_vld_r, s1_vld_nxt;
  logic    s2_vld_r, s2_vld_nxt;
  logic    s3_vld_r, s3_vld_nxt;
  logic    out_vld_r, out_vld_nxt;
  call_t   s0_r;
  tally_t  s1_r, s1_nxt;
  sums_t   s2_r, s2_nxt;
  prod_t   s3_r, s3_nxt;
  result_t out_r, out_nxt;
  tally_t  tally_r, tally_nxt;

  logic out_rdy, s3_rdy, s2_rdy, s1_rdy, s0_adv, in_rdy;

  assign out_rdy = !out_vld_r || out_chan.ready;
  assign s3_rdy  = !s3_vld_r || out_rdy;
  assign s2_rdy  = !s2_vld_r || s3_rdy;
  assign s1_rdy  = !s1_vld_r || s2_rdy;
  assign s0_adv  = s0_vld_r && (!s0_r.last_sample || s1_rdy);
  assign in_rdy  = !s0_vld_r || s0_adv;

  assign in_chan.ready = in_rdy;

  always_comb begin
    s0_vld_nxt  = in_rdy ? in_chan.valid : s0_vld_r;
    s1_vld_nxt  = s1_rdy ? (s0_adv && s0_r.last_sample) : s1_vld_r;
    s2_vld_nxt  = s2_rdy ? s1_vld_r : s2_vld_r;
    s3_vld_nxt  = s3_rdy ? s2_vld_r : s3_vld_r;
    out_vld_nxt = out_rdy ? s3_vld_r : out_vld_r;
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register and running tallies. A call counts only when both
  // its depth and quality meet the minimums; missing genotypes never count,
  // but every call is a sample. All tallies saturate rather than wrap.
  // --------------------------------------------------------------------------
  logic   qual;
  tally_t tally_upd;

  assign qual = (s0_r.depth >= min_depth_r) && (s0_r.quality >= min_quality_r);

  always_comb begin
    tally_upd = tally_r;
    if (qual && s0_r.genotype == GT_HOM_REF && tally_r.ref_cnt != TALLY_MAX) begin
      tally_upd.ref_cnt = tally_r.ref_cnt + TALLY_W'(1);
    end
    if (qual && s0_r.genotype == GT_HET && tally_r.het_cnt != TALLY_MAX) begin
      tally_upd.het_cnt = tally_r.het_cnt + TALLY_W'(1);
    end
    if (qual && s0_r.genotype == GT_HOM_ALT && tally_r.alt_cnt != TALLY_MAX) begin
      tally_upd.alt_cnt = tally_r.alt_cnt + TALLY_W'(1);
    end
    if (tally_r.smp_cnt < SAMPLE_MAX) begin
      tally_upd.smp_cnt = tally_r.smp_cnt + SAMPLE_W'(1);
    end

    // The final call of a variant hands its totals on and starts afresh.
    tally_nxt = tally_r;
    if (s0_adv) begin
      tally_nxt = s0_r.last_sample ? '0 : tally_upd;
    end
    s1_nxt = tally_upd;
  end

  // --------------------------------------------------------------------------
  // Stage 1: allele sums, minor and major, and the simple count filters.
  // --------------------------------------------------------------------------
  logic [ALLELE_W-1:0] ref_sum, alt_sum, major, minor;
  logic [PAIR_W-1:0]   ref_het, het_alt;

  always_comb begin
    ref_sum = ALLELE_W'({s1_r.ref_cnt, 1'b0}) + ALLELE_W'(s1_r.het_cnt);
    alt_sum = ALLELE_W'({s1_r.alt_cnt, 1'b0}) + ALLELE_W'(s1_r.het_cnt);
    major   = (ref_sum >= alt_sum) ? ref_sum : alt_sum;
    minor   = (ref_sum >= alt_sum) ? alt_sum : ref_sum;
    ref_het = PAIR_W'(s1_r.ref_cnt) + PAIR_W'(s1_r.het_cnt);
    het_alt = PAIR_W'(s1_r.het_cnt) + PAIR_W'(s1_r.alt_cnt);

    s2_nxt.ref_cnt   = s1_r.ref_cnt;
    s2_nxt.het_cnt   = s1_r.het_cnt;
    s2_nxt.alt_cnt   = s1_r.alt_cnt;
    s2_nxt.smp_cnt   = s1_r.smp_cnt;
    s2_nxt.minor     = minor;
    s2_nxt.total     = TOTAL_W'(major) + TOTAL_W'(minor);
    s2_nxt.calls     = CALLS_W'(s1_r.ref_cnt) + CALLS_W'(s1_r.het_cnt)
                     + CALLS_W'(s1_r.alt_cnt);
    s2_nxt.cnt_ok    = (minor >= ALLELE_W'(min_minor_count_r))
                    && (minor <= ALLELE_W'(max_minor_count_r));
    s2_nxt.allele_ok = (major != '0) && (minor != '0);
    // A variant carried by a single call on either side is a singleton.
    s2_nxt.single_ok = keep_singletons_r
                    || ((ref_het != PAIR_W'(1)) && (het_alt != PAIR_W'(1)));
  end

  // --------------------------------------------------------------------------
  // Stage 2: the three products that scale the thresholds, so that the
  // fraction tests compare exact integers with no rounding.
  // --------------------------------------------------------------------------
  always_comb begin
    s3_nxt.ref_cnt   = s2_r.ref_cnt;
    s3_nxt.het_cnt   = s2_r.het_cnt;
    s3_nxt.alt_cnt   = s2_r.alt_cnt;
    s3_nxt.minor     = s2_r.minor;
    s3_nxt.calls     = s2_r.calls;
    s3_nxt.rate_rhs  = RATE_PROD_W'(min_call_rate_r) * RATE_PROD_W'(s2_r.smp_cnt);
    s3_nxt.freq_lo   = FREQ_PROD_W'(min_freq_r) * FREQ_PROD_W'(s2_r.total);
    s3_nxt.freq_hi   = FREQ_PROD_W'(max_freq_r) * FREQ_PROD_W'(s2_r.total);
    s3_nxt.cnt_ok    = s2_r.cnt_ok;
    s3_nxt.allele_ok = s2_r.allele_ok;
    s3_nxt.single_ok = s2_r.single_ok;
  end

  // --------------------------------------------------------------------------
  // Stage 3: fraction comparisons and the pass decision. The call rate must be
  // strictly above its minimum; the frequency bounds are inclusive.
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] calls_q, minor_q;
  logic             rate_ok, freq_ok;

  always_comb begin
    calls_q = CMP_W'({s3_r.calls, FRAC_W'(0)});
    minor_q = CMP_W'({s3_r.minor, FRAC_W'(0)});
    rate_ok = calls_q > CMP_W'(s3_r.rate_rhs);
    freq_ok = (minor_q >= CMP_W'(s3_r.freq_lo)) && (minor_q <= CMP_W'(s3_r.freq_hi));

    out_nxt.hom_ref_count = s3_r.ref_cnt;
    out_nxt.het_count     = s3_r.het_cnt;
    out_nxt.hom_alt_count = s3_r.alt_cnt;
    out_nxt.minor_count   = (s3_r.minor > ALLELE_W'(MINOR_MAX)) ? MINOR_MAX
                                                                 : s3_r.minor[MINOR_W-1:0];
    out_nxt.passes        = rate_ok && freq_ok && s3_r.cnt_ok && s3_r.allele_ok
                         && s3_r.single_ok;
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      tally_r   <= '0;
    end else begin
      s0_vld_r  <= s0_vld_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      s3_vld_r  <= s3_vld_nxt;
      out_vld_r <= out_vld_nxt;
      tally_r   <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      s0_r.depth       <= in_chan.depth;
      s0_r.quality     <= in_chan.quality;
      s0_r.genotype    <= in_chan.genotype;
      s0_r.last_sample <= in_chan.last_sample;
    end
    if (s1_rdy) begin
      s1_r <= s1_nxt;
    end
    if (s2_rdy) begin
      s2_r <= s2_nxt;
    end
    if (s3_rdy) begin
      s3_r <= s3_nxt;
    end
    if (out_rdy) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.hom_ref_count = out_r.hom_ref_count;
  assign out_chan.het_count     = out_r.het_count;
  assign out_chan.hom_alt_count = out_r.hom_alt_count;
  assign out_chan.minor_count   = out_r.minor_count;
  assign out_chan.passes        = out_r.passes;

endmodule

FILE: hw/rtl/gcvq_checker.sv
// ============================================================================
// gcvq_checker: port-level assertions for the variant filter
// Checks result consistency and flow control as seen on the top-level ports.
// ============================================================================
module gcvq_checker import gcvq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TALLY_W-1:0] hom_ref_count,
  input logic [TALLY_W-1:0] het_count,
  input logic [TALLY_W-1:0] hom_alt_count,
  input logic [MINOR_W-1:0] minor_count,
  input logic               passes
);

  logic [ALLELE_W-1:0] ref_sum, alt_sum, minor_exp;
  logic [MINOR_W-1:0]  minor_sat;

  assign ref_sum   = ALLELE_W'({hom_ref_count, 1'b0}) + ALLELE_W'(het_count);
  assign alt_sum   = ALLELE_W'({hom_alt_count, 1'b0}) + ALLELE_W'(het_count);
  assign minor_exp = (ref_sum >= alt_sum) ? alt_sum : ref_sum;
  assign minor_sat = (minor_exp > ALLELE_W'(MINOR_MAX)) ? MINOR_MAX
                                                         : minor_exp[MINOR_W-1:0];

  // No result survives a reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hom_ref_count) && $stable(het_count)
      && $stable(hom_alt_count) && $stable(minor_count) && $stable(passes))
    else $error("stalled result changed");

  // The minor count is the smaller allele sum of the counts shown with it.
  a_minor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> minor_count == minor_sat)
    else $error("minor count does not match the genotype counts");

  // A passing variant has both alleles present.
  a_pass_alleles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && passes |-> minor_count != '0
      && (het_count != '0 || (hom_ref_count != '0 && hom_alt_count != '0)))
    else $error("variant passes without both alleles");

  // With the result side draining, the input is never held off.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while results are being taken");

endmodule

bind genotype_count_variant_qc gcvq_checker u_gcvq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .hom_ref_count (out_chan.hom_ref_count),
  .het_count     (out_chan.het_count),
  .hom_alt_count (out_chan.hom_alt_count),
  .minor_count   (out_chan.minor_count),
  .passes        (out_chan.passes)
);
